[rtl/core/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected components core.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MaxVertices = 32;
  localparam int MaxEdges    = 128;
  localparam int VW          = 5;   // vertex index width
  localparam int CW          = 6;   // vertex count width
  localparam int EW          = 7;   // edge index width
  localparam int ETW         = 8;   // edge total width

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ADD   = 2'd0;
  localparam cmd_t CMD_RUN   = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_START,
    ST_SCAN_RD,
    ST_SCAN,
    ST_RETURN,
    ST_POP,
    ST_PARENT,
    ST_OUT,
    ST_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic add_edge;
    logic clear_edges;
    logic init;          // reset run state, step root counter to 0
    logic visit_root;    // visit root vertex
    logic edge_rd;       // read edge at scan position of top frame
    logic scan_step;     // evaluate fetched edge
    logic ret;           // finish top frame
    logic pop;           // pop one vertex of component stack into output
    logic parent;        // fold low link into parent
    logic next_root;
    logic out_load;
    logic out_last;
  } cmd_bus_t;

  // datapath to controller
  typedef struct packed {
    logic root_done;     // root counter reached vertex count
    logic root_visited;
    logic scan_end;      // scan position at edge total
    logic is_root_comp;  // low link equals discovery time
    logic pop_hit;       // popped vertex is the returning vertex
    logic depth_zero;
    logic have_pend;     // a word is held for output
  } status_t;

endpackage

[rtl/core/scc_ctrl.sv]
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer for edge loading and the depth-first component search.
// ----------------------------------------------------------------------------
module scc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scc_pkg::cmd_t     in_cmd,
  input  logic              out_busy,
  input  scc_pkg::status_t  st,
  output scc_pkg::cmd_bus_t cb
);
  import scc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cb        = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_ADD:   cb.add_edge = 1'b1;
            CMD_RUN: begin
              cb.init   = 1'b1;
              state_nxt = ST_INIT;
            end
            CMD_CLEAR: cb.clear_edges = 1'b1;
            default: ;
          endcase
        end
      end
      ST_INIT: state_nxt = ST_START;
      ST_START: begin
        if (st.root_done) state_nxt = ST_FLUSH;
        else if (st.root_visited) cb.next_root = 1'b1;
        else begin
          cb.visit_root = 1'b1;
          state_nxt     = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (st.scan_end) state_nxt = ST_RETURN;
        else begin
          cb.edge_rd = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cb.scan_step = 1'b1;
        state_nxt    = ST_SCAN_RD;
      end
      ST_RETURN: begin
        cb.ret    = 1'b1;
        state_nxt = st.is_root_comp ? ST_POP : ST_PARENT;
      end
      ST_POP: begin
        if (!(st.have_pend && out_busy)) begin
          cb.pop = 1'b1;
          if (st.have_pend) cb.out_load = 1'b1;
          if (st.pop_hit) state_nxt = ST_PARENT;
        end
      end
      ST_PARENT: begin
        cb.parent = 1'b1;
        if (st.depth_zero) begin
          cb.next_root = 1'b1;
          state_nxt    = ST_START;
        end else state_nxt = ST_SCAN_RD;
      end
      ST_FLUSH: begin
        if (!st.have_pend) state_nxt = ST_IDLE;
        else if (!out_busy) begin
          cb.out_load = 1'b1;
          cb.out_last = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/scc_dp.sv]
// ----------------------------------------------------------------------------
// scc_dp
// Edge store, vertex tables, stacks and output register.
// ----------------------------------------------------------------------------
module scc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [scc_pkg::CW-1:0] cfg_count,
  input  logic [scc_pkg::VW-1:0] in_src_vertex,
  input  logic [scc_pkg::VW-1:0] in_dst_vertex,
  input  scc_pkg::cmd_bus_t    cb,
  output scc_pkg::status_t     st,
  input  logic                 out_ready,
  output logic                 out_busy,
  output logic                 out_valid,
  output logic [scc_pkg::VW-1:0] out_vertex,
  output logic                 out_component_end,
  output logic                 out_last
);
  import scc_pkg::*;

  logic [2*VW-1:0] edge_mem [MaxEdges];
  logic [2*VW-1:0] edge_q_r;
  logic [ETW-1:0]  edge_total_r;

  logic [CW-1:0] disc_r   [MaxVertices];
  logic [CW-1:0] low_r    [MaxVertices];
  logic [MaxVertices-1:0] onstk_r;
  logic [VW-1:0] cstk_r   [MaxVertices];
  logic [CW-1:0] ctop_r;
  logic [VW-1:0] call_v_r [MaxVertices];
  logic [ETW-1:0] call_p_r [MaxVertices];
  logic [CW-1:0] depth_r;
  logic [CW-1:0] clock_r;
  logic [CW-1:0] root_r;
  logic [VW-1:0] ret_v_r;

  logic [CW-1:0] n_eff;
  logic [VW-1:0] top_f, top_v, par_v, e_a, e_b, w_v;
  logic [ETW-1:0] top_p;
  logic [CW-1:0] new_clock;
  logic pend_r, pend_end_r;
  logic [VW-1:0] pend_v_r;
  logic ov_r, oend_r, olast_r;
  logic [VW-1:0] ov_v_r;
  logic edge_ok, vis_root, vis_edge;
  logic [VW-1:0] vis_v;

  assign n_eff     = (cfg_count > CW'(MaxVertices)) ? CW'(MaxVertices) : cfg_count;
  assign top_f     = VW'(depth_r - 1'b1);
  assign top_v     = call_v_r[top_f];
  assign top_p     = call_p_r[top_f];
  assign par_v     = call_v_r[VW'(depth_r - 1'b1)];
  assign e_a       = edge_q_r[2*VW-1:VW];
  assign e_b       = edge_q_r[VW-1:0];
  assign edge_ok   = (e_a == top_v) && ({1'b0, e_a} < n_eff) && ({1'b0, e_b} < n_eff);
  assign w_v       = cstk_r[VW'(ctop_r - 1'b1)];
  assign new_clock = clock_r + 1'b1;
  assign vis_root  = cb.visit_root;
  assign vis_edge  = cb.scan_step && edge_ok && (disc_r[e_b] == '0);
  assign vis_v     = vis_root ? root_r[VW-1:0] : e_b;

  always_comb begin
    st              = '0;
    st.root_done    = (root_r >= n_eff);
    st.root_visited = (disc_r[root_r[VW-1:0]] != '0);
    st.scan_end     = (top_p >= edge_total_r);
    st.is_root_comp = (low_r[top_v] == disc_r[top_v]);
    st.pop_hit      = (w_v == ret_v_r);
    st.depth_zero   = (depth_r == '0);
    st.have_pend    = pend_r;
  end

  // edge store
  always_ff @(posedge clk) begin
    if (cb.add_edge && ({1'b0, in_src_vertex} < n_eff) && ({1'b0, in_dst_vertex} < n_eff)
        && (edge_total_r < ETW'(MaxEdges)))
      edge_mem[edge_total_r[EW-1:0]] <= {in_src_vertex, in_dst_vertex};
    if (cb.edge_rd) edge_q_r <= edge_mem[top_p[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) edge_total_r <= '0;
    else if (cb.clear_edges) edge_total_r <= '0;
    else if (cb.add_edge && ({1'b0, in_src_vertex} < n_eff)
             && ({1'b0, in_dst_vertex} < n_eff) && (edge_total_r < ETW'(MaxEdges)))
      edge_total_r <= edge_total_r + 1'b1;
  end

  // search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      onstk_r <= '0;
      ctop_r  <= '0;
      depth_r <= '0;
      clock_r <= '0;
      root_r  <= '0;
      pend_r  <= 1'b0;
      for (int i = 0; i < MaxVertices; i++) disc_r[i] <= '0;
    end else begin
      if (cb.init) begin
        onstk_r <= '0;
        ctop_r  <= '0;
        depth_r <= '0;
        clock_r <= '0;
        root_r  <= '0;
        pend_r  <= 1'b0;
        for (int i = 0; i < MaxVertices; i++) disc_r[i] <= '0;
      end
      if (cb.next_root) root_r <= root_r + 1'b1;
      if (cb.scan_step) begin
        call_p_r[top_f] <= top_p + 1'b1;
        if (edge_ok && (disc_r[e_b] != '0) && onstk_r[e_b] && (disc_r[e_b] < low_r[top_v]))
          low_r[top_v] <= disc_r[e_b];
      end
      if (vis_root || vis_edge) begin
        clock_r           <= new_clock;
        disc_r[vis_v]     <= new_clock;
        low_r[vis_v]      <= new_clock;
        onstk_r[vis_v]    <= 1'b1;
        cstk_r[ctop_r[VW-1:0]] <= vis_v;
        ctop_r            <= ctop_r + 1'b1;
        call_v_r[depth_r[VW-1:0]] <= vis_v;
        call_p_r[depth_r[VW-1:0]] <= '0;
        depth_r           <= depth_r + 1'b1;
      end
      if (cb.ret) begin
        ret_v_r <= top_v;
        depth_r <= depth_r - 1'b1;
      end
      if (cb.pop) begin
        ctop_r      <= ctop_r - 1'b1;
        onstk_r[w_v] <= 1'b0;
        pend_r      <= 1'b1;
        pend_v_r    <= w_v;
        pend_end_r  <= (w_v == ret_v_r);
      end
      if (cb.parent && (depth_r != '0) && (low_r[ret_v_r] < low_r[par_v]))
        low_r[par_v] <= low_r[ret_v_r];
      if (cb.out_last) pend_r <= 1'b0;
    end
  end

  // output register
  assign out_busy = ov_r && !out_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cb.out_load) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cb.out_load) begin
      ov_v_r  <= pend_v_r;
      oend_r  <= pend_end_r;
      olast_r <= cb.out_last;
    end
  end

  assign out_valid         = ov_r;
  assign out_vertex        = ov_v_r;
  assign out_component_end = oend_r;
  assign out_last          = olast_r;

endmodule

[rtl/core/strongly_connected_components_core.sv]
// ----------------------------------------------------------------------------
// strongly_connected_components_core
// Tarjan component search over a stored directed edge list.
// ----------------------------------------------------------------------------
// Add and clear words are taken in the idle state. A run word holds the input
// until the search is done: every visited vertex reads and evaluates each
// stored edge in turn through the single read port of the edge store, with
// further steps for visiting, returning and popping. Each vertex is delivered
// once, one word a cycle at best, through a one-word output register.
module strongly_connected_components_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [scc_pkg::CW-1:0]  cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_cmd,
  input  logic [scc_pkg::VW-1:0]  in_src_vertex,
  input  logic [scc_pkg::VW-1:0]  in_dst_vertex,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [scc_pkg::VW-1:0]  out_vertex,
  output logic                    out_component_end,
  output logic                    out_last
);
  import scc_pkg::*;

  logic [CW-1:0] count_r;
  cmd_bus_t cb;
  status_t  st;
  logic     out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n)      count_r <= CW'(32);
    else if (cfg_we) count_r <= cfg_wdata;
  end

  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .out_busy (out_busy),
    .st       (st),
    .cb       (cb)
  );

  scc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_count         (count_r),
    .in_src_vertex     (in_src_vertex),
    .in_dst_vertex     (in_dst_vertex),
    .cb                (cb),
    .st                (st),
    .out_ready         (out_ready),
    .out_busy          (out_busy),
    .out_valid         (out_valid),
    .out_vertex        (out_vertex),
    .out_component_end (out_component_end),
    .out_last          (out_last)
  );

endmodule
